// ===== design/pntt_pkg.sv =====
// Package for the priority notice table: types, codes and reset constants.
`default_nettype none
package pntt_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 8;
  localparam logic [31:0] OFFLINE_LIMIT_RST = 32'd600000;
  localparam logic [31:0] MS_PER_S = 32'd1000;
  localparam int unsigned ADDR_W = 3;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_CLEAR_ALL = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  localparam logic REG_OFFLINE_LIMIT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINK,
    ST_SCAN,
    ST_PUSHW,
    ST_TOP
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  prio;
    logic [2:0]  style;
    logic [23:0] rgb;
    logic [15:0] lifetime;
    logic [31:0] start_ms;
    logic [7:0]  word;
    logic [31:0] order;
  } slot_t;

endpackage
`default_nettype wire

// ===== design/priority_notice_table_ttl_top.sv =====
// Top level of the priority notice table with lifetimes and link-loss wipe.
`default_nettype none
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | in_valid/in_ready  | kind, notice_key, priority_req, style, ...
//  output   | out_valid/out_ready| accepted, entry_count, top_valid, top_* ...
//  config   | APB psel/penable   | offline_limit_ms at byte address 0
//
//  Steps per item: accept, (tick: link check), scan of the held entries,
//  (push: write), top selection over the held entries; a clear-all, a
//  zero-key push or a link wipe skips the scan. One slot is read per cycle
//  through a single read index.
//  Reset is synchronous: table empty, order counter and link tracking cleared,
//  limit back to 600000 ms. A finished result sits in the output register;
//  the block takes the next item while it waits and stalls only at the end of
//  that item if the previous result is still not taken.
//
module priority_notice_table_ttl_top #(
  parameter int unsigned MAX_SLOTS = pntt_pkg::MAX_SLOTS_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1),
  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pntt_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // items in
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  kind,
  input  wire logic [31:0]                 notice_key,
  input  wire logic [7:0]                  priority_req,
  input  wire logic [2:0]                  style,
  input  wire logic [23:0]                 tint_rgb,
  input  wire logic [15:0]                 lifetime_s,
  input  wire logic [7:0]                  word_index,
  input  wire logic [31:0]                 now_ms,
  input  wire logic                        link_up,
  // results out
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             accepted,
  output logic [CNT_W-1:0]                 entry_count,
  output logic                             top_valid,
  output logic [31:0]                      top_key,
  output logic [7:0]                       top_priority,
  output logic [2:0]                       top_style,
  output logic [23:0]                      top_rgb,
  output logic [7:0]                       top_word
);

  // Slot store: one read index (idx), one write port per cycle.
  pntt_pkg::slot_t slots [MAX_SLOTS];

  pntt_pkg::state_t state, state_next;
  logic [31:0]      offline_limit;
  logic [CNT_W-1:0] used, used_next;
  logic [31:0]      next_order, next_order_next;
  logic             link_seen, link_seen_next;
  logic [31:0]      last_link, last_link_next;

  // latched item
  logic [1:0]  in_kind, in_kind_next;
  logic [31:0] in_key, in_key_next;
  logic [7:0]  in_prio, in_prio_next;
  logic [2:0]  in_style, in_style_next;
  logic [23:0] in_rgb, in_rgb_next;
  logic [15:0] in_life, in_life_next;
  logic [7:0]  in_word, in_word_next;
  logic [31:0] in_now, in_now_next;
  logic        in_up, in_up_next;

  // sequencer scratch
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] wr_ptr, wr_ptr_next;
  logic             found, found_next;
  logic [IDX_W-1:0] pos, pos_next;
  logic [7:0]       min_prio, min_prio_next;
  logic [IDX_W-1:0] min_idx, min_idx_next;
  logic             acc, acc_next;
  pntt_pkg::slot_t  best, best_next;

  // output register
  logic             out_valid_next;
  logic             accepted_next;
  logic [CNT_W-1:0] entry_count_next;
  logic             top_valid_next;
  pntt_pkg::slot_t  top_next;

  // slot write port
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  pntt_pkg::slot_t  wr_data;

  pntt_pkg::slot_t  rd;
  logic [31:0]      life_ms;
  logic             expired;
  logic             drop;
  logic             link_refresh;
  logic [31:0]      last_eff;
  logic             cfg_wr;

  assign rd = slots[idx[IDX_W-1:0]];
  // lifetime in ms; 16 x 10 bit product fits in 32 bits
  assign life_ms = 32'(rd.lifetime) * pntt_pkg::MS_PER_S;
  assign expired = (rd.lifetime != 16'd0) && ((in_now - rd.start_ms) >= life_ms);
  assign link_refresh = in_up || !link_seen;
  assign last_eff = link_refresh ? in_now : last_link;

  assign in_ready = (state == pntt_pkg::ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == pntt_pkg::REG_OFFLINE_LIMIT) ? offline_limit : 32'd0;

  always_comb begin
    state_next = state;
    used_next = used;
    next_order_next = next_order;
    link_seen_next = link_seen;
    last_link_next = last_link;
    in_kind_next = in_kind;
    in_key_next = in_key;
    in_prio_next = in_prio;
    in_style_next = in_style;
    in_rgb_next = in_rgb;
    in_life_next = in_life;
    in_word_next = in_word;
    in_now_next = in_now;
    in_up_next = in_up;
    idx_next = idx;
    wr_ptr_next = wr_ptr;
    found_next = found;
    pos_next = pos;
    min_prio_next = min_prio;
    min_idx_next = min_idx;
    acc_next = acc;
    best_next = best;
    out_valid_next = out_valid && !out_ready;
    accepted_next = accepted;
    entry_count_next = entry_count;
    top_valid_next = top_valid;
    top_next = '0;
    top_next.key = top_key;
    top_next.prio = top_priority;
    top_next.style = top_style;
    top_next.rgb = top_rgb;
    top_next.word = top_word;
    wr_en = 1'b0;
    wr_addr = wr_ptr[IDX_W-1:0];
    wr_data = rd;
    drop = 1'b0;

    unique case (state)
      pntt_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_kind_next = kind;
          in_key_next = notice_key;
          in_prio_next = priority_req;
          in_style_next = style;
          in_rgb_next = tint_rgb;
          in_life_next = lifetime_s;
          in_word_next = word_index;
          in_now_next = now_ms;
          in_up_next = link_up;
          idx_next = '0;
          wr_ptr_next = '0;
          found_next = 1'b0;
          acc_next = 1'b0;
          unique case (kind)
            pntt_pkg::KIND_PUSH:
              state_next = (notice_key == 32'd0) ? pntt_pkg::ST_TOP : pntt_pkg::ST_SCAN;
            pntt_pkg::KIND_CLEAR: state_next = pntt_pkg::ST_SCAN;
            pntt_pkg::KIND_CLEAR_ALL: begin
              used_next = '0;
              state_next = pntt_pkg::ST_TOP;
            end
            default: state_next = pntt_pkg::ST_LINK;
          endcase
        end
      end

      pntt_pkg::ST_LINK: begin
        if (link_refresh) last_link_next = in_now;
        if (in_up) link_seen_next = 1'b1;
        if ((link_seen || in_up) && ((in_now - last_eff) >= offline_limit)) begin
          used_next = '0;
          state_next = pntt_pkg::ST_TOP;
        end else begin
          state_next = pntt_pkg::ST_SCAN;
        end
      end

      pntt_pkg::ST_SCAN: begin
        if (idx < used) begin
          if (in_kind == pntt_pkg::KIND_PUSH) begin
            if (rd.key == in_key) begin
              found_next = 1'b1;
              pos_next = idx[IDX_W-1:0];
            end
            if (idx == '0 || rd.prio < min_prio) begin
              min_prio_next = rd.prio;
              min_idx_next = idx[IDX_W-1:0];
            end
          end else begin
            // compaction: survivors move down to wr_ptr
            if (in_kind == pntt_pkg::KIND_CLEAR) begin
              drop = (rd.key == in_key) && !found;
              if (drop) found_next = 1'b1;
            end else begin
              drop = expired;
            end
            if (!drop) begin
              wr_en = (wr_ptr != idx);
              wr_ptr_next = wr_ptr + 1'b1;
            end
          end
          idx_next = idx + 1'b1;
        end else begin
          idx_next = '0;
          if (in_kind == pntt_pkg::KIND_PUSH) begin
            state_next = pntt_pkg::ST_PUSHW;
          end else begin
            used_next = wr_ptr;
            acc_next = (in_kind == pntt_pkg::KIND_CLEAR) && found;
            state_next = pntt_pkg::ST_TOP;
          end
        end
      end

      pntt_pkg::ST_PUSHW: begin
        wr_data.key = in_key;
        wr_data.prio = in_prio;
        wr_data.style = in_style;
        wr_data.rgb = in_rgb;
        wr_data.lifetime = in_life;
        wr_data.start_ms = in_now;
        wr_data.word = in_word;
        wr_data.order = next_order;
        if (found) begin
          wr_en = 1'b1;
          wr_addr = pos;
        end else if (used < CNT_W'(MAX_SLOTS)) begin
          wr_en = 1'b1;
          wr_addr = used[IDX_W-1:0];
          used_next = used + 1'b1;
        end else if (min_prio < in_prio) begin
          wr_en = 1'b1;
          wr_addr = min_idx;
        end
        if (wr_en) begin
          acc_next = 1'b1;
          next_order_next = next_order + 32'd1;
        end
        state_next = pntt_pkg::ST_TOP;
      end

      pntt_pkg::ST_TOP: begin
        if (idx < used) begin
          if (idx == '0 || rd.prio > best.prio ||
              (rd.prio == best.prio && rd.order > best.order)) begin
            best_next = rd;
          end
          idx_next = idx + 1'b1;
        end else if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          accepted_next = acc;
          entry_count_next = used;
          top_valid_next = (used != '0);
          if (used != '0) top_next = best;
          else top_next = '0;
          state_next = pntt_pkg::ST_IDLE;
        end
      end

      default: state_next = pntt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pntt_pkg::ST_IDLE;
      used <= '0;
      next_order <= '0;
      link_seen <= 1'b0;
      last_link <= '0;
      offline_limit <= pntt_pkg::OFFLINE_LIMIT_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      used <= used_next;
      next_order <= next_order_next;
      link_seen <= link_seen_next;
      last_link <= last_link_next;
      out_valid <= out_valid_next;
      if (cfg_wr && paddr[2] == pntt_pkg::REG_OFFLINE_LIMIT) offline_limit <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    in_kind <= in_kind_next;
    in_key <= in_key_next;
    in_prio <= in_prio_next;
    in_style <= in_style_next;
    in_rgb <= in_rgb_next;
    in_life <= in_life_next;
    in_word <= in_word_next;
    in_now <= in_now_next;
    in_up <= in_up_next;
    idx <= idx_next;
    wr_ptr <= wr_ptr_next;
    found <= found_next;
    pos <= pos_next;
    min_prio <= min_prio_next;
    min_idx <= min_idx_next;
    acc <= acc_next;
    best <= best_next;
    accepted <= accepted_next;
    entry_count <= entry_count_next;
    top_valid <= top_valid_next;
    top_key <= top_next.key;
    top_priority <= top_next.prio;
    top_style <= top_next.style;
    top_rgb <= top_next.rgb;
    top_word <= top_next.word;
    if (wr_en) slots[wr_addr] <= wr_data;
  end

  // table never overfills
  assert property (@(posedge clk) disable iff (rst) used <= CNT_W'(MAX_SLOTS))
    else $error("entry count above table size");

  // reported top presence matches reported count
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (top_valid == (entry_count != '0)))
    else $error("top_valid disagrees with entry_count");

  // compaction pointer never runs ahead of the read index
  assert property (@(posedge clk) disable iff (rst)
    (state == pntt_pkg::ST_SCAN) |-> (wr_ptr <= idx))
    else $error("compaction write ahead of read");

  // a stored push advances the order counter exactly once
  assert property (@(posedge clk) disable iff (rst)
    (state == pntt_pkg::ST_PUSHW && wr_en) |=> (next_order == $past(next_order) + 32'd1))
    else $error("order counter not advanced on push");

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the priority notice table with lifetimes and link-loss wipe.
module tb;

  localparam int SLOTS = 8;
  localparam int AW = pntt_pkg::ADDR_W;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #4 clk = ~clk;

  // config port
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // item channel in
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  kind = pntt_pkg::KIND_PUSH;
  logic [31:0] notice_key = '0;
  logic [7:0]  priority_req = '0;
  logic [2:0]  style = '0;
  logic [23:0] tint_rgb = '0;
  logic [15:0] lifetime_s = '0;
  logic [7:0]  word_index = '0;
  logic [31:0] now_ms = '0;
  logic        link_up = 1'b0;

  // result channel out
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic [3:0]  entry_count;
  logic        top_valid;
  logic [31:0] top_key;
  logic [7:0]  top_priority;
  logic [2:0]  top_style;
  logic [23:0] top_rgb;
  logic [7:0]  top_word;

  priority_notice_table_ttl_top u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .kind, .notice_key, .priority_req, .style, .tint_rgb,
    .lifetime_s, .word_index, .now_ms, .link_up,
    .out_valid, .out_ready, .accepted, .entry_count, .top_valid, .top_key,
    .top_priority, .top_style, .top_rgb, .top_word
  );

  typedef struct packed {
    logic        acc;
    logic [3:0]  count;
    logic        valid;
    logic [31:0] key;
    logic [7:0]  prio;
    logic [2:0]  style;
    logic [23:0] rgb;
    logic [7:0]  word;
  } summary_t;

  // predictor state: shadow copy of the table
  pntt_pkg::slot_t tbl [SLOTS];
  int unsigned held;
  logic [31:0] order_ctr;
  logic        link_ever;
  logic [31:0] link_stamp;
  logic [31:0] wipe_limit;

  summary_t    pending_q[$];
  int          fail_cnt;
  int          result_cnt;
  int          push_ok_cnt, evict_cnt, wipe_cnt, expire_cnt;
  longint      cycles;

  // idling controls
  bit          calm;           // no idling at all
  bit          sink_hold;      // receiver held off
  logic [31:0] clock_ms;       // running time handed to the block

  function automatic int find_slot(logic [31:0] key);
    for (int i = 0; i < held; i++)
      if (tbl[i].key == key) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int pos);
    for (int k = pos; k + 1 < held; k++) tbl[k] = tbl[k + 1];
    held--;
  endfunction

  // Apply one item to the shadow table and return the expected summary.
  function automatic summary_t apply_notice(logic [1:0] k, logic [31:0] key, logic [7:0] pr,
      logic [2:0] st, logic [23:0] rgb, logic [15:0] life, logic [7:0] wd,
      logic [31:0] now, logic up);
    summary_t r;
    int pos, low, best, w;
    logic [31:0] span;
    r = '0;
    case (k)
      pntt_pkg::KIND_PUSH: begin
        if (key != 0) begin
          pos = find_slot(key);
          if (pos < 0 && held < SLOTS) begin
            pos = held;
            held++;
          end else if (pos < 0) begin
            low = 0;
            for (int i = 1; i < SLOTS; i++)
              if (tbl[i].prio < tbl[low].prio) low = i;
            if (tbl[low].prio < pr) begin
              pos = low;
              evict_cnt++;
            end
          end
          if (pos >= 0) begin
            tbl[pos] = '{key, pr, st, rgb, life, now, wd, order_ctr};
            order_ctr++;
            r.acc = 1'b1;
            push_ok_cnt++;
          end
        end
      end
      pntt_pkg::KIND_CLEAR: begin
        pos = (key == 0) ? -1 : find_slot(key);
        if (pos >= 0) begin
          drop_slot(pos);
          r.acc = 1'b1;
        end
      end
      pntt_pkg::KIND_CLEAR_ALL: held = 0;
      default: begin
        if (up || !link_ever) begin
          link_stamp = now;
          if (up) link_ever = 1'b1;
        end
        if (link_ever && (now - link_stamp) >= wipe_limit) begin
          if (held > 0) wipe_cnt++;
          held = 0;
        end else begin
          w = 0;
          for (int i = 0; i < held; i++) begin
            span = now - tbl[i].start_ms;
            if (tbl[i].lifetime != 0 &&
                span >= {16'd0, tbl[i].lifetime} * pntt_pkg::MS_PER_S)
              expire_cnt++;
            else begin
              tbl[w] = tbl[i];
              w++;
            end
          end
          held = w;
        end
      end
    endcase
    r.count = held[3:0];
    if (held > 0) begin
      best = 0;
      for (int i = 1; i < held; i++)
        if (tbl[i].prio > tbl[best].prio ||
            (tbl[i].prio == tbl[best].prio && tbl[i].order > tbl[best].order)) best = i;
      r.valid = 1'b1;
      r.key = tbl[best].key;
      r.prio = tbl[best].prio;
      r.style = tbl[best].style;
      r.rgb = tbl[best].rgb;
      r.word = tbl[best].word;
    end
    return r;
  endfunction

  // Offer one item, wait for acceptance, predict on acceptance.
  task automatic send_notice(logic [1:0] k, logic [31:0] key, logic [7:0] pr, logic [2:0] st,
      logic [23:0] rgb, logic [15:0] life, logic [7:0] wd, logic [31:0] now, logic up);
    while (!calm && $urandom_range(99) < 16) @(posedge clk);
    in_valid <= 1'b1;
    kind <= k; notice_key <= key; priority_req <= pr; style <= st; tint_rgb <= rgb;
    lifetime_s <= life; word_index <= wd; now_ms <= now; link_up <= up;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(apply_notice(k, key, pr, st, rgb, life, wd, now, up));
    in_valid <= 1'b0;
    // block leaves idle on every accept anyway
    @(posedge clk);
  endtask

  // Wait until every result is in, plus slack for the block to go idle.
  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_limit(logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AW'(4 * pntt_pkg::REG_OFFLINE_LIMIT); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    wipe_limit = value;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Result checker: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    summary_t exp_r;
    if (!rst && out_valid && out_ready) begin
      result_cnt++;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending");
        fail_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (accepted !== exp_r.acc) begin
          $error("accepted exp %0h got %0h", exp_r.acc, accepted); fail_cnt++;
        end
        if (entry_count !== exp_r.count) begin
          $error("entry_count exp %0d got %0d", exp_r.count, entry_count); fail_cnt++;
        end
        if (top_valid !== exp_r.valid) begin
          $error("top_valid exp %0h got %0h", exp_r.valid, top_valid); fail_cnt++;
        end
        if (top_key !== exp_r.key) begin
          $error("top_key exp %0h got %0h", exp_r.key, top_key); fail_cnt++;
        end
        if (top_priority !== exp_r.prio) begin
          $error("top_priority exp %0h got %0h", exp_r.prio, top_priority); fail_cnt++;
        end
        if (top_style !== exp_r.style) begin
          $error("top_style exp %0h got %0h", exp_r.style, top_style); fail_cnt++;
        end
        if (top_rgb !== exp_r.rgb) begin
          $error("top_rgb exp %0h got %0h", exp_r.rgb, top_rgb); fail_cnt++;
        end
        if (top_word !== exp_r.word) begin
          $error("top_word exp %0h got %0h", exp_r.word, top_word); fail_cnt++;
        end
      end
    end
  end

  // Receiver: random stalls, or a counted long hold-off when asked.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !sink_hold && (calm || $urandom_range(99) >= 16);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Random push with a small key pool so refreshes, clears and evictions hit.
  task automatic rand_push();
    send_notice(pntt_pkg::KIND_PUSH,
                ($urandom_range(19) == 0) ? 32'd0 : 32'($urandom_range(1, 14)),
                8'($urandom), 3'($urandom), 24'($urandom),
                ($urandom_range(2) == 0) ? 16'd0 : 16'($urandom_range(1, 6)),
                8'($urandom), clock_ms, 1'($urandom));
    clock_ms += $urandom_range(0, 1500);
  endtask

  task automatic test_directed();
    // empty table, key zero, extremes of every field, unlisted styles
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
    send_notice(pntt_pkg::KIND_PUSH, 0, 8'hFF, 3'd7, 24'hFFFFFF, 16'hFFFF, 8'hFF, 0, 1);
    send_notice(pntt_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    send_notice(pntt_pkg::KIND_PUSH, 32'hFFFFFFFF, 8'hFF, 3'd7, 24'hFFFFFF, 16'hFFFF, 8'hFF,
                32'hFFFFFFFF, 1);
    send_notice(pntt_pkg::KIND_PUSH, 32'd1, 8'h00, 3'd6, 24'h000000, 16'd0, 8'h00, 0, 0);
    send_notice(pntt_pkg::KIND_PUSH, 32'd2, 8'hFF, 3'd5, 24'hA5A5A5, 16'd1, 8'h5A,
                32'd100, 0);
    // tie on priority goes to newest; refresh restarts order
    send_notice(pntt_pkg::KIND_PUSH, 32'hFFFFFFFF, 8'hFF, 3'd4, 24'h123456, 16'd2, 8'd3,
                32'd200, 0);
    // fill to eight; the push of key 8 evicts the lowest (key 1)
    for (int i = 3; i <= 8; i++)
      send_notice(pntt_pkg::KIND_PUSH, i, 8'(i * 10), 3'(i), 24'(i), 16'd0, 8'(i),
                  32'd300, 0);
    // full: lower priorities are rejected
    send_notice(pntt_pkg::KIND_PUSH, 32'd50, 8'h00, 0, 0, 0, 0, 32'd400, 0);
    send_notice(pntt_pkg::KIND_PUSH, 32'd51, 8'h01, 1, 1, 0, 1, 32'd400, 0);
    send_notice(pntt_pkg::KIND_CLEAR, 32'd5, 0, 0, 0, 0, 0, 0, 0);
    send_notice(pntt_pkg::KIND_CLEAR, 32'd99, 0, 0, 0, 0, 0, 0, 0);
    // expiry exactly at lifetime (key 2: start 100, 1 s)
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'd1099, 1);
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'd1100, 1);
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'd2200, 1);
    // wrap of now against an old start
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'hFFFFF000, 1);
    send_notice(pntt_pkg::KIND_CLEAR_ALL, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_offline_wipe();
    // limit 0: every tick wipes once the link has been seen
    write_limit(32'd0);
    send_notice(pntt_pkg::KIND_PUSH, 32'd7, 8'd9, 0, 24'h00FF00, 0, 0, 32'd10, 0);
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'd20, 0);
    drain();
    write_limit(32'd5000);
    send_notice(pntt_pkg::KIND_PUSH, 32'd8, 8'd9, 0, 24'h0000FF, 0, 0, 32'd30, 0);
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'd4000, 0);
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'd7000, 0);
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'd9000, 1);
    drain();
    write_limit(32'hFFFFFFFF);
    send_notice(pntt_pkg::KIND_PUSH, 32'd9, 8'd1, 0, 0, 0, 0, 32'd0, 0);
    send_notice(pntt_pkg::KIND_TICK, 0, 0, 0, 0, 0, 0, 32'h80000000, 0);
    drain();
  endtask

  task automatic test_backpressure();
    // hold the receiver while items keep coming, so the block stalls its input
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(posedge clk);
        sink_hold = 1'b0;
      end
      repeat (12) rand_push();
    join
    drain();
  endtask

  task automatic test_random(int n, logic [31:0] lim);
    int pick;
    write_limit(lim);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 3 + 40);
      pick = $urandom_range(99);
      if (pick < 55) rand_push();
      else if (pick < 72)
        send_notice(pntt_pkg::KIND_CLEAR, ($urandom_range(9) == 0) ? 32'($urandom) :
                    32'($urandom_range(0, 14)), 8'($urandom), 3'($urandom), 24'($urandom),
                    16'($urandom), 8'($urandom), 32'($urandom), 1'($urandom));
      else if (pick < 75)
        send_notice(pntt_pkg::KIND_CLEAR_ALL, 32'($urandom), 8'($urandom), 3'($urandom),
                    24'($urandom), 16'($urandom), 8'($urandom), 32'($urandom), 1'($urandom));
      else begin
        clock_ms += $urandom_range(0, 4000);
        send_notice(pntt_pkg::KIND_TICK, 32'($urandom), 8'($urandom), 3'($urandom),
                    24'($urandom), 16'($urandom), 8'($urandom), clock_ms,
                    $urandom_range(3) != 0);
      end
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    held = 0; order_ctr = '0; link_ever = 1'b0; link_stamp = '0;
    wipe_limit = pntt_pkg::OFFLINE_LIMIT_RST;
    fail_cnt = 0; result_cnt = 0; cycles = 0;
    push_ok_cnt = 0; evict_cnt = 0; wipe_cnt = 0; expire_cnt = 0;
    calm = 1'b0; sink_hold = 1'b0; clock_ms = 32'hFFFF0000;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_offline_wipe();
    test_backpressure();
    test_random(200, 32'd6000);
    test_random(180, pntt_pkg::OFFLINE_LIMIT_RST);
    $display("covered %0d results: %0d pushes stored, %0d evictions, %0d expiries, %0d wipes",
             result_cnt, push_ok_cnt, evict_cnt, expire_cnt, wipe_cnt);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/pntt_pkg.sv
design/priority_notice_table_ttl_top.sv
sim/tb.sv
